// ===== sv/aesp_pkg.sv =====
// shared types and constants for the terminal escape-sequence parser
// no dependencies

package aesp_pkg;

    localparam int MAX_PARAMS      = 16;
    localparam int STRING_CAPACITY = 256;

    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_BEL  = 8'h07;
    localparam logic [7:0] CH_ST   = 8'h9C;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LPAR = 8'h28;
    localparam logic [7:0] CH_RPAR = 8'h29;
    localparam logic [7:0] CH_LBRK = 8'h5B;
    localparam logic [7:0] CH_RBRK = 8'h5D;
    localparam logic [7:0] CH_QMRK = 8'h3F;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_ZERO = 8'h30;

    typedef enum logic [2:0] {
        KIND_PARAM   = 3'd0,
        KIND_STR     = 3'd1,
        KIND_DONE    = 3'd2,
        KIND_ERR     = 3'd3,
        KIND_ABANDON = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] param_value;
        logic        param_absent;
        logic [7:0]  char_out;
        logic [7:0]  seq_class;
        logic        extended;
        logic [4:0]  param_count;
        logic        param_overflow;
    } result_t;

    // one accepted byte: an optional parameter result ahead of the main result
    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } item_t;

endpackage

// ===== sv/ansi_escape_sequence_parser.sv =====
// terminal escape-sequence parser: byte automaton, parameter and string capture
// depends on aesp_pkg
//
// usage:
//   s_* channel takes one terminal byte per transaction in s_tdata[7:0].
//   m_* channel returns result records; m_tuser carries the kind, m_tlast
//   marks the last record caused by one input byte. a byte may cause zero,
//   one or two records (two only for a parameter followed by a final byte).
// timing:
//   each accepted byte is classified and its records written into a
//   two-entry result queue in the same cycle; the first record is visible
//   on m_* once that queue entry is registered and reaches the head.
//   one byte per cycle is sustained while m_tready stays high and no byte
//   gives two records; such a byte holds the queue head until both are taken.
// reset:
//   rst_n low returns the automaton to the start state, clears the sequence
//   context and empties the result queue.
// stall:
//   with m_tready low the queue fills after two records-bearing bytes and
//   s_tready drops until the last record of the head entry is taken; nothing is lost.

module ansi_escape_sequence_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // param_value, param_absent, char_out, seq_class,
                                   // extended, param_count, param_overflow
    output logic [2:0]  m_tuser,   // kind
    output logic        m_tlast    // last
);

    typedef enum logic [2:0] {
        ST_START,
        ST_ESC,
        ST_CSI,
        ST_OSC,
        ST_CLS
    } state_t;

    state_t      state_reg, state_next;
    logic [15:0] acc_reg, acc_next;
    logic        seen_reg, seen_next;
    logic [7:0]  cls_reg, cls_next;
    logic        ext_reg, ext_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        ovf_reg, ovf_next;
    logic [8:0]  slen_reg, slen_next;

    aesp_pkg::item_t q_reg [2];
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [1:0]      fill_reg;
    logic            phase_reg;

    logic            accept;
    logic [7:0]      c;
    logic            is_cmd, is_dig;
    logic            emit_param, emit_main, to_start;
    aesp_pkg::kind_t main_kind;
    logic [7:0]      main_char;
    logic            store_ok;
    logic [19:0]     acc_mul;
    logic [9:0]      slen_inc;
    logic [15:0]     upd_acc;
    logic            upd_seen;
    logic [7:0]      upd_cls;
    logic            upd_ext;
    logic [4:0]      upd_cnt;
    logic            upd_ovf;
    logic [8:0]      upd_slen;
    state_t          upd_state;
    aesp_pkg::item_t new_item;
    logic            push, pop, out_fire, out_last;
    aesp_pkg::item_t head;
    aesp_pkg::result_t out_res;

    assign accept   = s_tvalid && s_tready;
    assign c        = s_tdata;
    assign is_cmd   = (c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h3C:8'h3E]});
    assign is_dig   = (c inside {[8'h30:8'h39]});
    assign store_ok = cnt_reg < 5'(aesp_pkg::MAX_PARAMS);
    assign acc_mul  = ({4'd0, acc_reg} * 20'd10) + {12'd0, c - aesp_pkg::CH_ZERO};
    assign slen_inc = {1'b0, slen_reg} + 10'd1;

    always_comb
    begin
        emit_param = 1'b0;
        emit_main  = 1'b0;
        to_start   = 1'b0;
        main_kind  = aesp_pkg::KIND_ERR;
        main_char  = c;
        upd_acc    = acc_reg;
        upd_seen   = seen_reg;
        upd_cls    = cls_reg;
        upd_ext    = ext_reg;
        upd_cnt    = cnt_reg;
        upd_ovf    = ovf_reg;
        upd_slen   = slen_reg;
        upd_state  = state_reg;
        if (c == aesp_pkg::CH_ESC)
        begin
            emit_main = (state_reg != ST_START);
            main_kind = aesp_pkg::KIND_ABANDON;
            upd_state = ST_ESC;
        end
        else
        begin
            case (state_reg)
                ST_ESC:
                begin
                    if (is_cmd || is_dig)
                    begin
                        emit_main = 1'b1;
                        main_kind = aesp_pkg::KIND_DONE;
                        to_start  = 1'b1;
                    end
                    else if (c == aesp_pkg::CH_HASH || c == aesp_pkg::CH_LPAR
                             || c == aesp_pkg::CH_RPAR)
                    begin
                        upd_cls   = c;
                        upd_state = ST_CLS;
                    end
                    else if (c == aesp_pkg::CH_LBRK)
                    begin
                        upd_cls   = c;
                        upd_state = ST_CSI;
                    end
                    else if (c == aesp_pkg::CH_RBRK)
                    begin
                        upd_cls   = c;
                        upd_state = ST_OSC;
                    end
                    else
                    begin
                        emit_main = 1'b1;
                        to_start  = 1'b1;
                    end
                end
                ST_CSI:
                begin
                    if (is_cmd)
                    begin
                        if (seen_reg)
                        begin
                            emit_param = store_ok;
                            upd_cnt    = cnt_reg + 5'(store_ok);
                            upd_ovf    = ovf_reg | ~store_ok;
                        end
                        emit_main = 1'b1;
                        main_kind = aesp_pkg::KIND_DONE;
                        to_start  = 1'b1;
                    end
                    else if (is_dig)
                    begin
                        upd_acc  = (acc_mul > 20'd65535) ? 16'hFFFF : acc_mul[15:0];
                        upd_seen = 1'b1;
                    end
                    else if (c == aesp_pkg::CH_QMRK)
                    begin
                        upd_ext = 1'b1;
                    end
                    else if (c == aesp_pkg::CH_SEMI)
                    begin
                        emit_param = store_ok;
                        upd_cnt    = cnt_reg + 5'(store_ok);
                        upd_ovf    = ovf_reg | ~store_ok;
                        upd_acc    = 16'd0;
                        upd_seen   = 1'b0;
                    end
                    else
                    begin
                        emit_main = 1'b1;
                        to_start  = 1'b1;
                    end
                end
                ST_OSC:
                begin
                    if (c == aesp_pkg::CH_BEL || c == aesp_pkg::CH_ST)
                    begin
                        emit_main = 1'b1;
                        main_kind = aesp_pkg::KIND_DONE;
                        main_char = 8'd0;
                        to_start  = 1'b1;
                    end
                    else if (slen_inc < 10'(aesp_pkg::STRING_CAPACITY))
                    begin
                        upd_slen  = slen_inc[8:0];
                        emit_main = 1'b1;
                        main_kind = aesp_pkg::KIND_STR;
                    end
                end
                ST_CLS:
                begin
                    emit_main = 1'b1;
                    main_kind = (is_cmd || is_dig) ? aesp_pkg::KIND_DONE : aesp_pkg::KIND_ERR;
                    to_start  = 1'b1;
                end
                default:
                begin
                    emit_main = 1'b1;
                    to_start  = 1'b1;
                end
            endcase
        end
    end

    // parameter result lands in the main slot when it is the only record
    always_comb
    begin
        new_item.first.kind           = aesp_pkg::KIND_PARAM;
        new_item.first.param_value    = seen_reg ? acc_reg : 16'd0;
        new_item.first.param_absent   = ~seen_reg;
        new_item.first.char_out       = 8'd0;
        new_item.first.seq_class      = upd_cls;
        new_item.first.extended       = upd_ext;
        new_item.first.param_count    = upd_cnt;
        new_item.first.param_overflow = upd_ovf;
        new_item.two                  = emit_param && emit_main;
        if (emit_main)
        begin
            new_item.second.kind           = main_kind;
            new_item.second.param_value    = 16'd0;
            new_item.second.param_absent   = 1'b0;
            new_item.second.char_out       = main_char;
            new_item.second.seq_class      = upd_cls;
            new_item.second.extended       = upd_ext;
            new_item.second.param_count    = upd_cnt;
            new_item.second.param_overflow = upd_ovf;
        end
        else
        begin
            new_item.second = new_item.first;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        seen_next  = seen_reg;
        cls_next   = cls_reg;
        ext_next   = ext_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        slen_next  = slen_reg;
        if (accept)
        begin
            if (to_start || c == aesp_pkg::CH_ESC)
            begin
                state_next = to_start ? ST_START : upd_state;
                acc_next   = 16'd0;
                seen_next  = 1'b0;
                cls_next   = 8'd0;
                ext_next   = 1'b0;
                cnt_next   = 5'd0;
                ovf_next   = 1'b0;
                slen_next  = 9'd0;
            end
            else
            begin
                state_next = upd_state;
                acc_next   = upd_acc;
                seen_next  = upd_seen;
                cls_next   = upd_cls;
                ext_next   = upd_ext;
                cnt_next   = upd_cnt;
                ovf_next   = upd_ovf;
                slen_next  = upd_slen;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_START;
            acc_reg   <= 16'd0;
            seen_reg  <= 1'b0;
            cls_reg   <= 8'd0;
            ext_reg   <= 1'b0;
            cnt_reg   <= 5'd0;
            ovf_reg   <= 1'b0;
            slen_reg  <= 9'd0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            seen_reg  <= seen_next;
            cls_reg   <= cls_next;
            ext_reg   <= ext_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            slen_reg  <= slen_next;
        end
    end

    // result queue
    assign head     = q_reg[rd_ptr_reg];
    assign out_res  = (head.two && !phase_reg) ? head.first : head.second;
    assign out_last = !(head.two && !phase_reg);
    assign out_fire = m_tvalid && m_tready;
    assign pop      = out_fire && out_last;
    assign push     = accept && (emit_param || emit_main);
    assign s_tready = (fill_reg != 2'd2);
    assign m_tvalid = (fill_reg != 2'd0);
    assign m_tuser  = out_res.kind;
    assign m_tlast  = out_last;
    assign m_tdata  = {out_res.param_overflow, out_res.param_count, out_res.extended,
                       out_res.seq_class, out_res.char_out, out_res.param_absent,
                       out_res.param_value};

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
            phase_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
                phase_reg  <= 1'b0;
            end
            else if (out_fire)
            begin
                phase_reg <= 1'b1;
            end
            fill_reg <= fill_reg + 2'(push) - 2'(pop);
        end
    end

endmodule
